/* rtl/core/wmm_pkg.sv */
// Shared types and constants for the windowed min/max peak tracker.
`default_nettype none

package wmm_pkg;

	// Width of every sample-valued port and of the threshold register
	localparam int unsigned FIELD_W = 14;

	// Threshold value after reset
	localparam logic [FIELD_W-1:0] THRESHOLD_RESET = 14'd100;

	// Item kinds on the input channel
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_CLEAR  = 1'b1;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// Control from the sequencer to the min/max accumulator
	typedef struct packed {
		logic start;	// reset the running extremes
		logic beat;	// read data from the history memory is present
		logic keep;	// entry has been written since reset, else it counts as zero
	} scan_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/wmm_history_ram.sv */
// Sample history memory: one write port, one registered read port.
`default_nettype none

module wmm_history_ram #(
	parameter int unsigned DEPTH = 128,
	parameter int unsigned AW    = 7,
	parameter int unsigned W     = 14
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata
);

	logic [W-1:0] history_q [DEPTH];
	logic [W-1:0] rdata_q;

	// Write the new sample
	always_ff @(posedge clk) begin
		if (we) begin
			history_q[waddr] <= wdata;
		end
	end

	// Read one entry, data registered and valid in the next cycle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= history_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* rtl/core/wmm_scan.sv */
// Running minimum and maximum over the entries read from the history memory.
`default_nettype none

module wmm_scan #(
	parameter int unsigned W = 14
) (
	input  wire logic               clk,
	input  wire wmm_pkg::scan_ctl_t ctl,
	input  wire logic [W-1:0]       rdata,
	output logic      [W-1:0]       lo,
	output logic      [W-1:0]       hi
);

	logic [W-1:0] lo_q;
	logic [W-1:0] hi_q;
	logic [W-1:0] entry;

	// Entries never written since reset read as zero
	assign entry = ctl.keep ? rdata : '0;

	// Restart on a new item, fold in each entry as it arrives
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			lo_q <= '1;
			hi_q <= '0;
		end else if (ctl.beat) begin
			if (entry < lo_q) begin
				lo_q <= entry;
			end
			if (entry > hi_q) begin
				hi_q <= entry;
			end
		end
	end

	assign lo = lo_q;
	assign hi = hi_q;

endmodule

`default_nettype wire

/* rtl/core/windowed_min_max_peak_tracker.sv */
// Top level of the windowed min/max and all-time peak tracker.
`default_nettype none

// The block keeps the newest WINDOW temperature samples in a circular memory
// and gives one result per input item: the minimum and maximum over the
// window, the newest sample, the all-time peak (zeroed by a clear item) and a
// flag that the newest sample was above the threshold in force when it was
// stored. Until WINDOW samples have arrived, the unwritten slots count as
// zero; this is tracked by the write pointer and a full flag, so there is no
// clearing pass after reset. Per item, IDLE takes it and writes the memory,
// SCAN reads every entry through the single read port, DRAIN waits for the
// last read data and DONE loads the output register, waiting while that
// still holds an untaken result; no new item is taken before DONE is left.
// A finished result waits in the output register while the next item is
// taken. Samples keep only their low SAMPLE_BITS bits. The threshold may be
// written only while the block is idle.

module windowed_min_max_peak_tracker #(
	parameter int unsigned WINDOW      = 128,
	parameter int unsigned SAMPLE_BITS = 14
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [wmm_pkg::FIELD_W-1:0]  cfg_wdata,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         kind,
	input  wire logic [wmm_pkg::FIELD_W-1:0]  sample,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic      [wmm_pkg::FIELD_W-1:0]  window_max,
	output logic      [wmm_pkg::FIELD_W-1:0]  window_min,
	output logic      [wmm_pkg::FIELD_W-1:0]  peak_value,
	output logic      [wmm_pkg::FIELD_W-1:0]  newest_sample,
	output logic                              measure_enable
);

	localparam int unsigned AW = $clog2(WINDOW);
	localparam int unsigned FW = wmm_pkg::FIELD_W;
	localparam int unsigned CW = FW + SAMPLE_BITS;
	localparam logic [AW-1:0] LAST_ADDR = AW'(WINDOW - 1);

	wmm_pkg::state_t    state_q, state_d;
	wmm_pkg::scan_ctl_t scan_ctl;

	logic [FW-1:0]          threshold_q;
	logic [AW-1:0]          wp_q;
	logic                   full_q;
	logic [SAMPLE_BITS-1:0] peak_q;
	logic [SAMPLE_BITS-1:0] newest_q;
	logic                   enable_q;

	logic [AW-1:0]          rd_cnt_q;
	logic                   beat_s1;
	logic [AW-1:0]          idx_s1;

	logic                   out_valid_q;
	logic [FW-1:0]          out_max_q;
	logic [FW-1:0]          out_min_q;
	logic [FW-1:0]          out_peak_q;
	logic [FW-1:0]          out_newest_q;
	logic                   out_enable_q;

	logic                   in_xfer;
	logic                   out_xfer;
	logic                   store;
	logic                   rd_en;
	logic                   load_out;
	logic [CW-1:0]          sample_ext;
	logic [SAMPLE_BITS-1:0] s_w;
	logic                   above;
	logic [SAMPLE_BITS-1:0] rdata;
	logic [SAMPLE_BITS-1:0] scan_lo;
	logic [SAMPLE_BITS-1:0] scan_hi;
	logic [CW-1:0]          max_ext;
	logic [CW-1:0]          min_ext;
	logic [CW-1:0]          peak_ext;
	logic [CW-1:0]          newest_ext;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid_q && out_ready;
	assign store    = in_xfer && (kind == wmm_pkg::KIND_SAMPLE);

	// Keep the low SAMPLE_BITS bits of the sample
	assign sample_ext = {{SAMPLE_BITS{1'b0}}, sample};
	assign s_w        = sample_ext[SAMPLE_BITS-1:0];
	assign above      = {{FW{1'b0}}, s_w} > {{SAMPLE_BITS{1'b0}}, threshold_q};

	// Sequencer: next state and strobes
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		rd_en    = 1'b0;
		load_out = 1'b0;
		case (state_q)
			wmm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = wmm_pkg::ST_SCAN;
				end
			end
			wmm_pkg::ST_SCAN: begin
				rd_en = 1'b1;
				if (rd_cnt_q == LAST_ADDR) begin
					state_d = wmm_pkg::ST_DRAIN;
				end
			end
			wmm_pkg::ST_DRAIN: begin
				state_d = wmm_pkg::ST_DONE;
			end
			wmm_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = wmm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = wmm_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wmm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold the threshold written on the configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= wmm_pkg::THRESHOLD_RESET;
		end else if (cfg_we) begin
			threshold_q <= cfg_wdata;
		end
	end

	// Advance the write pointer, note when the window has filled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			full_q <= 1'b0;
		end else if (store) begin
			if (wp_q == LAST_ADDR) begin
				wp_q   <= '0;
				full_q <= 1'b1;
			end else begin
				wp_q <= wp_q + 1'b1;
			end
		end
	end

	// Update peak, newest sample and enable flag; drop the peak on a clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q   <= '0;
			newest_q <= '0;
			enable_q <= 1'b0;
		end else if (store) begin
			if (s_w > peak_q) begin
				peak_q <= s_w;
			end
			newest_q <= s_w;
			enable_q <= above;
		end else if (in_xfer) begin
			peak_q <= '0;
		end
	end

	// Step the read address through the window, track read data with a registered beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q <= '0;
			beat_s1  <= 1'b0;
		end else begin
			beat_s1 <= rd_en;
			if (in_xfer) begin
				rd_cnt_q <= '0;
			end else if (rd_en) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_cnt_q;
	end

	wmm_history_ram #(
		.DEPTH (WINDOW),
		.AW    (AW),
		.W     (SAMPLE_BITS)
	) u_ram (
		.clk   (clk),
		.we    (store),
		.waddr (wp_q),
		.wdata (s_w),
		.re    (rd_en),
		.raddr (rd_cnt_q),
		.rdata (rdata)
	);

	// Slots at or beyond the write pointer are unwritten until the window fills
	assign scan_ctl.start = in_xfer;
	assign scan_ctl.beat  = beat_s1;
	assign scan_ctl.keep  = full_q || (idx_s1 < wp_q);

	wmm_scan #(
		.W (SAMPLE_BITS)
	) u_scan (
		.clk   (clk),
		.ctl   (scan_ctl),
		.rdata (rdata),
		.lo    (scan_lo),
		.hi    (scan_hi)
	);

	assign max_ext    = {{FW{1'b0}}, scan_hi};
	assign min_ext    = {{FW{1'b0}}, scan_lo};
	assign peak_ext   = {{FW{1'b0}}, peak_q};
	assign newest_ext = {{FW{1'b0}}, newest_q};

	// Output register: load a finished result, release it on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_max_q    <= max_ext[FW-1:0];
			out_min_q    <= min_ext[FW-1:0];
			out_peak_q   <= peak_ext[FW-1:0];
			out_newest_q <= newest_ext[FW-1:0];
			out_enable_q <= enable_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign window_max     = out_max_q;
	assign window_min     = out_min_q;
	assign peak_value     = out_peak_q;
	assign newest_sample  = out_newest_q;
	assign measure_enable = out_enable_q;

endmodule

`default_nettype wire

/* verif/tb_windowed_min_max_peak_tracker.sv */
// Self-checking testbench for the windowed min/max and all-time peak tracker.
`default_nettype none

module tb_windowed_min_max_peak_tracker;

	localparam int unsigned WINDOW      = 128;
	localparam int unsigned SAMPLE_BITS = 14;
	localparam int unsigned RANDOM_ITEMS = 1400;
	localparam int unsigned CFG_EVERY    = 350;
	localparam int unsigned DRAIN_CYCLES = 140;
	localparam longint unsigned CYCLE_LIMIT = 4000000;

	typedef logic [wmm_pkg::FIELD_W-1:0] field_t;

	// One result as the block should present it
	typedef struct packed {
		field_t wmax;
		field_t wmin;
		field_t peak;
		field_t newest;
		logic   enable;
	} tracker_result_t;

	logic   clk = 1'b0;
	logic   arst_n;
	logic   cfg_we;
	field_t cfg_wdata;
	logic   in_valid;
	logic   in_ready;
	logic   kind;
	field_t sample;
	logic   out_valid;
	logic   out_ready;
	field_t window_max;
	field_t window_min;
	field_t peak_value;
	field_t newest_sample;
	logic   measure_enable;

	// Mirror of the tracker state
	field_t         hist_mem [WINDOW];
	logic [6:0]     hist_wr_ptr;
	field_t         peak_hold;
	logic           enable_hold;
	field_t         threshold_reg;

	tracker_result_t pending_results [$];

	int unsigned     error_count = 0;
	longint unsigned cycle_count = 0;
	bit              idle_on = 1'b1;
	int unsigned     hold_cycles = 0;

	windowed_min_max_peak_tracker #(
		.WINDOW      (WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.kind           (kind),
		.sample         (sample),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.window_max     (window_max),
		.window_min     (window_min),
		.peak_value     (peak_value),
		.newest_sample  (newest_sample),
		.measure_enable (measure_enable)
	);

	// Free-running clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a run that has hung
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Mostly short idles, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(20, 200);
	endfunction

	// Update the mirrored state with one item and form the result it causes
	function automatic tracker_result_t compute_window_result(logic k, field_t s);
		tracker_result_t res;
		field_t          lo;
		field_t          hi;
		if (k == wmm_pkg::KIND_SAMPLE) begin
			hist_mem[hist_wr_ptr] = s;
			hist_wr_ptr           = hist_wr_ptr + 7'd1;
			if (s > peak_hold)
				peak_hold = s;
			enable_hold = (s > threshold_reg);
		end else begin
			peak_hold = '0;
		end
		lo = hist_mem[0];
		hi = hist_mem[0];
		for (int i = 1; i < WINDOW; i++) begin
			if (hist_mem[i] > hi)
				hi = hist_mem[i];
			if (hist_mem[i] < lo)
				lo = hist_mem[i];
		end
		res.wmax   = hi;
		res.wmin   = lo;
		res.peak   = peak_hold;
		res.newest = hist_mem[hist_wr_ptr - 7'd1];
		res.enable = enable_hold;
		return res;
	endfunction

	task automatic report_mismatch(string what, field_t got, field_t want);
		$display("mismatch at cycle %0d: %s got %0d want %0d",
			cycle_count, what, got, want);
		error_count++;
	endtask

	// Compare each result transfer with the oldest expectation, then log new inputs
	always @(posedge clk) begin
		tracker_result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected result, pending count",
						field_t'(1), field_t'(0));
				end else begin
					want = pending_results.pop_front();
					if (window_max !== want.wmax)
						report_mismatch("window_max", window_max, want.wmax);
					if (window_min !== want.wmin)
						report_mismatch("window_min", window_min, want.wmin);
					if (peak_value !== want.peak)
						report_mismatch("peak_value", peak_value, want.peak);
					if (newest_sample !== want.newest)
						report_mismatch("newest_sample", newest_sample, want.newest);
					if (measure_enable !== want.enable)
						report_mismatch("measure_enable", field_t'(measure_enable),
							field_t'(want.enable));
				end
			end
			if (in_valid && in_ready)
				pending_results.push_back(compute_window_result(kind, sample));
		end
	end

	// Drive the result ready: a long hold-off when one is set, else random stalls while idles are on
	initial begin
		int unsigned rx_stall;
		rx_stall  = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_ready = 1'b0;
				hold_cycles--;
			end else if (rx_stall > 0) begin
				out_ready = 1'b0;
				rx_stall--;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				out_ready = 1'b0;
				rx_stall  = pick_gap();
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	// Offer one item and hold it until the transfer; starts and ends on a falling edge
	task automatic send_item(logic k, field_t s);
		int unsigned gap;
		gap = idle_on ? pick_gap() : 0;
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		kind     = k;
		sample   = s;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// Wait until every expected result has been taken
	task automatic wait_drained();
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_threshold(field_t v);
		wait_drained();
		cfg_wdata = v;
		cfg_we    = 1'b1;
		@(negedge clk);
		cfg_we        = 1'b0;
		threshold_reg = v;
	endtask

	// Reset contents, extreme samples, threshold boundary and peak clearing
	task automatic test_reset_and_peak();
		send_item(wmm_pkg::KIND_CLEAR, 14'h3FFF);
		send_item(wmm_pkg::KIND_SAMPLE, 14'h3FFF);
		send_item(wmm_pkg::KIND_SAMPLE, 14'h0000);
		send_item(wmm_pkg::KIND_SAMPLE, wmm_pkg::THRESHOLD_RESET);
		send_item(wmm_pkg::KIND_SAMPLE, wmm_pkg::THRESHOLD_RESET + 14'd1);
		send_item(wmm_pkg::KIND_CLEAR, 14'h0000);
		send_item(wmm_pkg::KIND_SAMPLE, 14'd5);
		send_item(wmm_pkg::KIND_CLEAR, 14'h2AAA);
	endtask

	// Threshold at both ends; a change leaves the stored flag alone
	task automatic test_threshold_extremes();
		write_threshold(14'h0000);
		send_item(wmm_pkg::KIND_SAMPLE, 14'h0000);
		send_item(wmm_pkg::KIND_SAMPLE, 14'h0001);
		write_threshold(14'h3FFF);
		send_item(wmm_pkg::KIND_CLEAR, 14'h1555);
		send_item(wmm_pkg::KIND_SAMPLE, 14'h3FFF);
		send_item(wmm_pkg::KIND_SAMPLE, 14'h3FFE);
		write_threshold(wmm_pkg::THRESHOLD_RESET);
		send_item(wmm_pkg::KIND_CLEAR, 14'h0000);
	endtask

	// Hold the receiver off while items keep coming, so the input stalls
	task automatic test_output_backpressure();
		wait_drained();
		idle_on     = 1'b0;
		hold_cycles = 1500;
		for (int i = 0; i < 6; i++)
			send_item(wmm_pkg::KIND_SAMPLE, field_t'($urandom_range(0, 16383)));
		wait_drained();
		idle_on = 1'b1;
	endtask

	// Segments of samples in a random band, with clears, idles and threshold changes
	task automatic test_random_traffic();
		int unsigned sent;
		int unsigned next_cfg;
		int unsigned seg_len;
		int unsigned base;
		int unsigned spread;
		int unsigned v;
		sent     = 0;
		next_cfg = CFG_EVERY;
		while (sent < RANDOM_ITEMS) begin
			if (sent >= next_cfg) begin
				write_threshold(field_t'($urandom_range(0, 16383)));
				next_cfg += CFG_EVERY;
			end
			seg_len = $urandom_range(40, 250);
			base    = $urandom_range(0, 16383);
			spread  = 1 << $urandom_range(0, 14);
			idle_on = ($urandom_range(0, 3) != 0);
			for (int i = 0; i < seg_len && sent < RANDOM_ITEMS; i++) begin
				if ($urandom_range(0, 99) < 8) begin
					send_item(wmm_pkg::KIND_CLEAR, field_t'($urandom_range(0, 16383)));
				end else begin
					v = base + $urandom_range(0, spread - 1);
					if (v > 16383)
						v = 16383;
					send_item(wmm_pkg::KIND_SAMPLE, field_t'(v));
				end
				sent++;
			end
		end
		idle_on = 1'b1;
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		in_valid  = 1'b0;
		kind      = wmm_pkg::KIND_SAMPLE;
		sample    = '0;
		for (int i = 0; i < WINDOW; i++)
			hist_mem[i] = '0;
		hist_wr_ptr   = '0;
		peak_hold     = '0;
		enable_hold   = 1'b0;
		threshold_reg = wmm_pkg::THRESHOLD_RESET;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_and_peak();
		test_threshold_extremes();
		test_output_backpressure();
		test_random_traffic();

		// Let the last results out, then report the outcome
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
